### hw/rtl/bets_pkg.sv
// Shared types and constants for the bounded earliest-time selector.
// No dependencies; bets_if, bets_ctrl and the top level use this package.
`default_nettype none
package bets_pkg;

	localparam int MAX_KEPT  = 16;
	localparam int IDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W     = $clog2(MAX_KEPT + 1);
	localparam int CAP_W     = 5;
	localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;
	localparam int TIME_W    = 32;
	localparam int ID_W      = 16;
	localparam int KIND_W    = 2;
	localparam int RANK_W    = 4;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] tstamp;
		logic [ID_W-1:0]   id;
		logic [KIND_W-1:0] kind;
	} entry_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] tstamp;
		logic [RANK_W-1:0] rank;
		logic              none_kept;
		logic              last;
	} result_t;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_ADD_RD   = 6'b000010,
		S_ADD_SCAN = 6'b000100,
		S_ADD_FIN  = 6'b001000,
		S_DRN_RD   = 6'b010000,
		S_DRN_WB   = 6'b100000
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/bets_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on bets_pkg for field widths.
`default_nettype none
interface bets_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [bets_pkg::TIME_W-1:0]  update_time;
	logic [bets_pkg::ID_W-1:0]    light_id;
	logic [bets_pkg::KIND_W-1:0]  light_kind;

	modport source (output valid, req_type, update_time, light_id, light_kind, input ready);
	modport sink   (input valid, req_type, update_time, light_id, light_kind, output ready);
endinterface

interface bets_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bets_pkg::ID_W-1:0]    out_id;
	logic [bets_pkg::KIND_W-1:0]  out_kind;
	logic [bets_pkg::TIME_W-1:0]  out_time;
	logic [bets_pkg::RANK_W-1:0]  out_rank;
	logic                         none_kept;
	logic                         last;

	modport source (output valid, out_id, out_kind, out_time, out_rank, none_kept, last,
		input ready);
	modport sink   (input valid, out_id, out_kind, out_time, out_rank, none_kept, last,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/bets_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module bets_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/bets_ctrl.sv
// Sequencer for sorted insertion and drain over the entry RAM.
// Depends on bets_pkg and bets_ram.
`default_nettype none
module bets_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [bets_pkg::CAP_W-1:0]    capacity,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire bets_pkg::entry_t              req_entry,
	input  wire logic                          req_drain,
	input  wire logic                          out_busy,
	output logic                               res_load,
	output bets_pkg::result_t                  res
);
	import bets_pkg::*;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	entry_t             item_q;
	logic [IDX_W-1:0]   j_q;
	logic [CNT_W-1:0]   pos_q;
	logic [IDX_W-1:0]   k_q;

	logic [CNT_W-1:0]   cap_eff;
	logic [CNT_W-1:0]   m;
	logic [CNT_W-1:0]   tgt;
	logic               later;
	logic               is_last;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	entry_t             ram_rdata;

	bets_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_KEPT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (CMP_W'(capacity) > CMP_W'(MAX_KEPT)) begin
			cap_eff = CNT_W'(MAX_KEPT);
		end else begin
			cap_eff = CNT_W'(capacity);
		end
		m       = (count_q < cap_eff) ? count_q : cap_eff;
		tgt     = CNT_W'(j_q) + CNT_W'(1);
		later   = ram_rdata.tstamp > item_q.tstamp;
		is_last = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = item_q;
		ram_raddr = j_q;
		res_load  = 1'b0;
		res       = '0;
		case (state_q)
			S_ADD_RD: begin
				ram_raddr = IDX_W'(m - CNT_W'(1));
			end
			S_ADD_SCAN: begin
				ram_raddr = j_q - IDX_W'(1);
				if (later && (tgt < cap_eff)) begin
					ram_we    = 1'b1;
					ram_waddr = tgt[IDX_W-1:0];
					ram_wdata = ram_rdata;
				end
			end
			S_ADD_FIN: begin
				if (pos_q < cap_eff) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[IDX_W-1:0];
				end
			end
			S_DRN_RD: begin
				ram_raddr = k_q;
				if (!out_busy && (count_q == '0)) begin
					res_load      = 1'b1;
					res.none_kept = 1'b1;
					res.last      = 1'b1;
				end
			end
			S_DRN_WB: begin
				res_load   = 1'b1;
				res.id     = ram_rdata.id;
				res.kind   = ram_rdata.kind;
				res.tstamp = ram_rdata.tstamp;
				res.rank   = RANK_W'(k_q);
				res.last   = is_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= req_drain ? S_DRN_RD : S_ADD_RD;
					end
				end
				S_ADD_RD: begin
					state_q <= (m == '0) ? S_ADD_FIN : S_ADD_SCAN;
				end
				S_ADD_SCAN: begin
					if (!later || (j_q == '0)) begin
						state_q <= S_ADD_FIN;
					end
				end
				S_ADD_FIN: begin
					if (pos_q < cap_eff) begin
						count_q <= (count_q >= cap_eff) ? cap_eff : count_q + CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				S_DRN_RD: begin
					if (!out_busy) begin
						state_q <= (count_q == '0) ? S_IDLE : S_DRN_WB;
					end
				end
				S_DRN_WB: begin
					if (is_last) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DRN_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					item_q <= req_entry;
					k_q    <= '0;
				end
			end
			S_ADD_RD: begin
				j_q   <= IDX_W'(m - CNT_W'(1));
				pos_q <= '0;
			end
			S_ADD_SCAN: begin
				if (!later) begin
					pos_q <= tgt;
				end else if (j_q == '0) begin
					pos_q <= '0;
				end else begin
					j_q <= j_q - IDX_W'(1);
				end
			end
			S_DRN_WB: begin
				k_q <= k_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEPT))
		else $error("kept count exceeds MAX_KEPT");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("entry RAM written while idle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !out_busy)
		else $error("result loaded into a full output register");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.last) |=> (count_q == '0))
		else $error("list not cleared after drain");

	a_write_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) < cap_eff))
		else $error("entry written beyond capacity");
endmodule
`default_nettype wire

### hw/rtl/bounded_earliest_time_selector.sv
// Top level of the bounded earliest-time selector: config register, output register.
// Depends on bets_pkg, bets_if and bets_ctrl.
//
// Usage:
//   req channel carries add items (req_type 0) and drain items (req_type 1).
//   rsp channel carries one result per kept entry on a drain, in ascending time
//   order, with last set on the final one; a drain of an empty list gives a
//   single result with none_kept and last set.
//   cfg_we/cfg_wdata write capacity; write it only while the block is idle.
// Timing:
//   An item is taken only when the sequencer is idle. An add on an empty list goes
//   from S_ADD_RD to S_ADD_FIN; else S_ADD_SCAN compares one entry per step (each
//   entry later than the new time and the first one that is not) before S_ADD_FIN.
//   A drain reads each entry in S_DRN_RD once the output register is free and loads
//   it in S_DRN_WB; an empty drain loads its single result from S_DRN_RD. The first
//   result passes the registered RAM read and then the output register.
// Reset: clears the kept count and sets capacity to 4; the entry RAM is not cleared.
// Stall:
//   A result holds in the output register until taken; a drain waits on it,
//   while a new item is accepted as soon as the sequencer is idle.
`default_nettype none
module bounded_earliest_time_selector (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bets_pkg::CAP_W-1:0]  cfg_wdata,
	bets_req_if.sink                         req,
	bets_rsp_if.source                       rsp
);
	import bets_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             out_valid_q;
	result_t          out_q;
	entry_t           req_entry;
	logic             res_load;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_comb begin
		req_entry.tstamp = req.update_time;
		req_entry.id     = req.light_id;
		req_entry.kind   = req.light_kind;
	end

	bets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_entry (req_entry),
		.req_drain (req.req_type == REQ_DRAIN),
		.out_busy  (out_valid_q),
		.res_load  (res_load),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_id    = out_q.id;
	assign rsp.out_kind  = out_q.kind;
	assign rsp.out_time  = out_q.tstamp;
	assign rsp.out_rank  = out_q.rank;
	assign rsp.none_kept = out_q.none_kept;
	assign rsp.last      = out_q.last;
endmodule
`default_nettype wire
